// File: rtl/core/gha_pkg.sv
package gha_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 1024;
  localparam int unsigned GEN_BITS_DEF  = 16;
  localparam int unsigned OBJ_W         = 32;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESOLVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_STALE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

// File: rtl/core/gha_ram.sv
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/generational_handle_allocator.sv
// Generational handle allocator. Each beat is an acquire, release or resolve
// request, and each gives exactly one result beat. The block handles one
// request at a time: an acquire served from the free stack does a stack read,
// a slot read, a slot write and the result load; a release or resolve of an
// in-range non-null handle does a slot read and the result load; every other
// request goes straight to the result load. The slot table and free stack
// memories have registered reads and are read back to back for a recycled
// slot. The next request is taken as soon as the controller is idle again,
// even while the previous result still waits in the output register. The
// memories need no clearing after reset: only slots below the append count
// and stack entries below the stack top are ever read.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int unsigned GEN_BITS  = GEN_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [$clog2(NUM_SLOTS)-1:0] slot_index_i,
  input  logic [GEN_BITS-1:0]          handle_generation_i,
  input  logic [OBJ_W-1:0]             object_id_i,
  input  logic                         owned_flag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [$clog2(NUM_SLOTS)-1:0] out_index_o,
  output logic [GEN_BITS-1:0]          out_generation_o,
  output logic [OBJ_W-1:0]             out_object_o,
  output logic                         is_owned_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SLOT_W = OBJ_W + GEN_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_POP_WAIT  = 4'b0010,
    S_SLOT_WAIT = 4'b0100,
    S_DONE      = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] free_top_q, free_top_d;
  logic [CNT_W-1:0] in_use_q, in_use_d;

  // Request held while it is worked on.
  op_e               op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [GEN_BITS-1:0] gen_q, gen_d;
  logic [OBJ_W-1:0]  obj_q, obj_d;
  logic              own_q, own_d;

  // Result waiting to be moved into the output register.
  status_e             res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_index_q, res_index_d;
  logic [GEN_BITS-1:0] res_gen_q, res_gen_d;
  logic [OBJ_W-1:0]    res_obj_q, res_obj_d;
  logic                res_own_q, res_own_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [GEN_BITS-1:0] out_gen_q;
  logic [OBJ_W-1:0]    out_obj_q;
  logic                out_own_q;
  logic                out_load;

  // Slot table port signals.
  logic              slot_we, slot_re;
  logic [IDX_W-1:0]  slot_waddr, slot_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic [OBJ_W-1:0]  rd_obj;
  logic [GEN_BITS-1:0] rd_gen, gen_inc;
  logic              rd_own, rd_occ;

  // Free stack port signals.
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic             accept;
  logic [CNT_W-1:0] top_dec;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign top_dec = free_top_q - CNT_W'(1);

  assign rd_obj  = slot_rdata[SLOT_W-1 -: OBJ_W];
  assign rd_gen  = slot_rdata[GEN_BITS+1:2];
  assign rd_own  = slot_rdata[1];
  assign rd_occ  = slot_rdata[0];
  assign gen_inc = rd_gen + GEN_BITS'(1);

  always_comb begin
    state_d      = state_q;
    free_top_d   = free_top_q;
    in_use_d     = in_use_q;
    op_d         = op_q;
    idx_d        = idx_q;
    gen_d        = gen_q;
    obj_d        = obj_q;
    own_d        = own_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_gen_d    = res_gen_q;
    res_obj_d    = res_obj_q;
    res_own_d    = res_own_q;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    slot_waddr   = idx_q;
    slot_raddr   = idx_q;
    slot_wdata   = {obj_q, rd_gen, own_q, 1'b1};
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = free_top_q[IDX_W-1:0];
    stk_raddr    = top_dec[IDX_W-1:0];
    stk_wdata    = idx_q;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = op_e'(op_i);
          idx_d        = slot_index_i;
          gen_d        = handle_generation_i;
          obj_d        = object_id_i;
          own_d        = owned_flag_i;
          res_status_d = ST_OK;
          res_index_d  = '0;
          res_gen_d    = '0;
          res_obj_d    = '0;
          res_own_d    = 1'b0;
          state_d      = S_DONE;
          case (op_e'(op_i))
            OP_ACQUIRE: begin
              if (free_top_q != '0) begin
                stk_re     = 1'b1;
                free_top_d = top_dec;
                state_d    = S_POP_WAIT;
              end else if (in_use_q != CNT_W'(NUM_SLOTS)) begin
                // Append a fresh slot with the first valid generation.
                slot_we     = 1'b1;
                slot_waddr  = in_use_q[IDX_W-1:0];
                slot_wdata  = {object_id_i, GEN_BITS'(1), owned_flag_i, 1'b1};
                in_use_d    = in_use_q + CNT_W'(1);
                res_index_d = in_use_q[IDX_W-1:0];
                res_gen_d   = GEN_BITS'(1);
              end else begin
                res_status_d = ST_FULL;
              end
            end
            OP_RELEASE, OP_RESOLVE: begin
              if (handle_generation_i == '0 ||
                  CNT_W'(slot_index_i) >= in_use_q) begin
                res_status_d = ST_NULL;
              end else begin
                slot_re    = 1'b1;
                slot_raddr = slot_index_i;
                state_d    = S_SLOT_WAIT;
              end
            end
            default: begin
              res_status_d = ST_NULL;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        idx_d      = stk_rdata;
        slot_re    = 1'b1;
        slot_raddr = stk_rdata;
        state_d    = S_SLOT_WAIT;
      end
      S_SLOT_WAIT: begin
        state_d = S_DONE;
        case (op_q)
          OP_ACQUIRE: begin
            // A recycled slot keeps the generation its last release left.
            slot_we     = 1'b1;
            slot_wdata  = {obj_q, rd_gen, own_q, 1'b1};
            res_index_d = idx_q;
            res_gen_d   = rd_gen;
          end
          OP_RELEASE: begin
            if (rd_gen != gen_q || !rd_occ) begin
              res_status_d = ST_STALE;
            end else begin
              slot_we    = 1'b1;
              slot_wdata = {{OBJ_W{1'b0}}, gen_inc, 1'b0, 1'b0};
              // A slot whose generation wrapped is retired for good.
              if (gen_inc != '0 && free_top_q != CNT_W'(NUM_SLOTS)) begin
                stk_we     = 1'b1;
                free_top_d = free_top_q + CNT_W'(1);
              end
            end
          end
          OP_RESOLVE: begin
            if (rd_gen != gen_q || !rd_occ) begin
              res_status_d = ST_STALE;
            end else begin
              res_obj_d = rd_obj;
              res_own_d = rd_own;
            end
          end
          default: begin
            res_status_d = ST_NULL;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_top_q  <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_top_q  <= free_top_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    gen_q        <= gen_d;
    obj_q        <= obj_d;
    own_q        <= own_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_gen_q    <= res_gen_d;
    res_obj_q    <= res_obj_d;
    res_own_q    <= res_own_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_gen_q    <= res_gen_q;
      out_obj_q    <= res_obj_q;
      out_own_q    <= res_own_q;
    end
  end

  gha_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (slot_re),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  gha_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NUM_SLOTS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign out_object_o     = out_obj_q;
  assign is_owned_o       = out_own_q;

`ifndef NO_ASSERTIONS
  // Every stacked slot is a distinct appended slot.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= in_use_q)
    else $error("free stack holds more slots than were ever appended");

  a_append_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= CNT_W'(NUM_SLOTS))
    else $error("append count exceeds the table size");

  a_append_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> in_use_q >= $past(in_use_q))
    else $error("append count decreased");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the done state");
`endif

endmodule
